// ----- rtl/kee_pkg.sv -----
// ----------------------------------------------------------------------------
// kee_pkg
// Shared types and codes for the key event escape encoder.
// ----------------------------------------------------------------------------
package kee_pkg;

	localparam int SEQ_MAX = 8;

	// key codes
	localparam logic [5:0] KEY_CHAR      = 6'd0;
	localparam logic [5:0] KEY_ENTER     = 6'd1;
	localparam logic [5:0] KEY_TAB       = 6'd2;
	localparam logic [5:0] KEY_BACKSPACE = 6'd3;
	localparam logic [5:0] KEY_ESCAPE    = 6'd4;
	localparam logic [5:0] KEY_UP        = 6'd5;
	localparam logic [5:0] KEY_END       = 6'd10;
	localparam logic [5:0] KEY_INSERT    = 6'd11;
	localparam logic [5:0] KEY_PAGE_DOWN = 6'd14;
	localparam logic [5:0] KEY_F1        = 6'd15;
	localparam logic [5:0] KEY_F4        = 6'd18;
	localparam logic [5:0] KEY_F5        = 6'd19;
	localparam logic [5:0] KEY_F20       = 6'd34;
	localparam logic [5:0] KEY_KP_0      = 6'd35;
	localparam logic [5:0] KEY_KP_EQUALS = 6'd52;
	localparam logic [4:0] KP_ENTER_IDX  = 5'd10;

	// configuration register indexes
	localparam logic [2:0] CFG_NEWLINE_MODE  = 3'd0;
	localparam logic [2:0] CFG_BS_DELETE     = 3'd1;
	localparam logic [2:0] CFG_APP_CURSOR    = 3'd2;
	localparam logic [2:0] CFG_APP_KEYPAD    = 3'd3;
	localparam logic [2:0] CFG_ALT_ESCAPE    = 3'd4;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;

	typedef struct packed {
		logic [5:0]  key_code;
		logic [3:0]  modifiers;
		logic [20:0] char_code;
	} kee_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} kee_out_t;

	typedef struct packed {
		logic crlf_on_enter;
		logic bs_is_del;
		logic cursor_ss3;
		logic keypad_app;
		logic alt_esc_prefix;
	} kee_cfg_t;

	// one encoded event: bytes[0] goes out first, len is 1..8
	typedef struct packed {
		logic [SEQ_MAX-1:0][7:0] bytes;
		logic [3:0]              len;
	} kee_seq_t;

	typedef struct packed {
		logic full;
		logic valid;
	} kee_qstat_t;

endpackage

// ----- rtl/kee_front.sv -----
// ----------------------------------------------------------------------------
// kee_front
// Accepts key events, classifies them and builds the byte sequence.
// ----------------------------------------------------------------------------
module kee_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  kee_pkg::kee_in_t in_item,
	input  kee_pkg::kee_cfg_t cfg,
	input  kee_pkg::kee_qstat_t qstat,
	output logic             push,
	output kee_pkg::kee_seq_t push_seq
);
	import kee_pkg::*;

	function automatic logic [7:0] cursor_final(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = "A";
			3'd1: r = "B";
			3'd2: r = "C";
			3'd3: r = "D";
			3'd4: r = "H";
			default: r = "F";
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ss3_final(input logic [1:0] i);
		logic [7:0] r;
		unique case (i)
			2'd0: r = "P";
			2'd1: r = "Q";
			2'd2: r = "R";
			default: r = "S";
		endcase
		return r;
	endfunction

	function automatic logic [5:0] tilde_named(input logic [1:0] i);
		logic [5:0] r;
		unique case (i)
			2'd0: r = 6'd2;
			2'd1: r = 6'd3;
			2'd2: r = 6'd5;
			default: r = 6'd6;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] fkey_tilde(input logic [3:0] i);
		logic [5:0] r;
		unique case (i)
			4'd0: r = 6'd15;
			4'd1: r = 6'd17;
			4'd2: r = 6'd18;
			4'd3: r = 6'd19;
			4'd4: r = 6'd20;
			4'd5: r = 6'd21;
			4'd6: r = 6'd23;
			4'd7: r = 6'd24;
			4'd8: r = 6'd25;
			4'd9: r = 6'd26;
			4'd10: r = 6'd28;
			4'd11: r = 6'd29;
			4'd12: r = 6'd31;
			4'd13: r = 6'd32;
			4'd14: r = 6'd33;
			default: r = 6'd34;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kp_app(input logic [4:0] i);
		logic [7:0] r;
		unique case (i)
			5'd0: r = "p";
			5'd1: r = "q";
			5'd2: r = "r";
			5'd3: r = "s";
			5'd4: r = "t";
			5'd5: r = "u";
			5'd6: r = "v";
			5'd7: r = "w";
			5'd8: r = "x";
			5'd9: r = "y";
			5'd10: r = "M";
			5'd11: r = "k";
			5'd12: r = "m";
			5'd13: r = "j";
			5'd14: r = "o";
			5'd15: r = "n";
			5'd16: r = "l";
			default: r = "X";
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kp_num(input logic [4:0] i);
		logic [7:0] r;
		unique case (i)
			5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9:
				r = 8'h30 | {3'd0, i};
			5'd11: r = "+";
			5'd12: r = "-";
			5'd13: r = "*";
			5'd14: r = "/";
			5'd15: r = ".";
			5'd16: r = ",";
			default: r = "=";
		endcase
		return r;
	endfunction

	// tens digit of a value up to 39
	function automatic logic [1:0] dec_tens(input logic [5:0] v);
		logic [1:0] t;
		if (v >= 6'd30) t = 2'd3;
		else if (v >= 6'd20) t = 2'd2;
		else if (v >= 6'd10) t = 2'd1;
		else t = 2'd0;
		return t;
	endfunction

	function automatic logic [7:0] dec_ones(input logic [5:0] v, input logic [1:0] t);
		logic [5:0] o;
		o = v - {1'b0, t, 3'b000} - {3'b000, t, 1'b0};
		return 8'h30 | {4'd0, o[3:0]};
	endfunction

	// ctrl mapping of a character; valid flag in bit 8
	function automatic logic [8:0] ctrl_byte(input logic [20:0] c);
		logic [8:0] r;
		if (c >= 21'h61 && c <= 21'h7A) r = {1'b1, 3'd0, c[4:0]};
		else if (c >= 21'h41 && c <= 21'h5A) r = {1'b1, 3'd0, c[4:0]};
		else begin
			case (c)
				21'h20, 21'h40, 21'h32: r = {1'b1, 8'h00};
				21'h5B, 21'h33: r = {1'b1, 8'h1B};
				21'h5C, 21'h34: r = {1'b1, 8'h1C};
				21'h5D, 21'h35: r = {1'b1, 8'h1D};
				21'h5E, 21'h36: r = {1'b1, 8'h1E};
				21'h5F, 21'h37, 21'h2F: r = {1'b1, 8'h1F};
				21'h38, 21'h3F: r = {1'b1, 8'h7F};
				default: r = 9'd0;
			endcase
		end
		return r;
	endfunction

	logic    valid_s1;
	kee_in_t item_s1;
	logic    advance;

	assign in_stall = valid_s1 && qstat.full;
	assign advance  = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= in_item;
		end
	end

	logic [7:0] b [SEQ_MAX];
	logic [3:0] n;
	logic [4:0] mod;
	logic       shift, alt, ctrl;
	logic [5:0] key, rel, num, modw;
	logic [20:0] cp;
	logic [8:0] cb;
	logic [7:0] fin;
	logic       do_cursor, do_tilde, app, do_alt;
	logic [1:0] t;

	always_comb begin
		key   = item_s1.key_code;
		cp    = item_s1.char_code;
		mod   = 5'd1 + {1'b0, item_s1.modifiers};
		modw  = {1'b0, mod};
		shift = item_s1.modifiers[0];
		alt   = item_s1.modifiers[1];
		ctrl  = item_s1.modifiers[2];
		cb    = ctrl_byte(cp);
		for (int i = 0; i < SEQ_MAX; i++) b[i] = 8'h00;
		n         = 4'd0;
		rel       = 6'd0;
		num       = 6'd0;
		fin       = 8'h00;
		app       = 1'b0;
		do_cursor = 1'b0;
		do_tilde  = 1'b0;
		t         = 2'd0;

		case (key) inside
			KEY_CHAR: begin
				if (cp != 21'd0) begin
					if (ctrl && cb[8]) begin
						b[0] = cb[7:0];
						n = 4'd1;
					end else if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
						n = 4'd0;
					end else if (cp < 21'h80) begin
						b[0] = {1'b0, cp[6:0]};
						n = 4'd1;
					end else if (cp < 21'h800) begin
						b[0] = {3'b110, cp[10:6]};
						b[1] = {2'b10, cp[5:0]};
						n = 4'd2;
					end else if (cp < 21'h10000) begin
						b[0] = {4'b1110, cp[15:12]};
						b[1] = {2'b10, cp[11:6]};
						b[2] = {2'b10, cp[5:0]};
						n = 4'd3;
					end else begin
						b[0] = {5'b11110, cp[20:18]};
						b[1] = {2'b10, cp[17:12]};
						b[2] = {2'b10, cp[11:6]};
						b[3] = {2'b10, cp[5:0]};
						n = 4'd4;
					end
				end
			end
			KEY_ENTER: begin
				b[0] = CH_CR;
				b[1] = CH_LF;
				n = cfg.crlf_on_enter ? 4'd2 : 4'd1;
			end
			KEY_TAB: begin
				if (shift) begin
					b[0] = CH_ESC;
					b[1] = "[";
					b[2] = "Z";
					n = 4'd3;
				end else if (mod > 5'd1) begin
					b[0] = CH_ESC;
					b[1] = "[";
					b[2] = "9";
					b[3] = ";";
					if (mod >= 5'd10) begin
						b[4] = "1";
						b[5] = dec_ones(modw, 2'd1);
						b[6] = "u";
						n = 4'd7;
					end else begin
						b[4] = 8'h30 | {4'd0, mod[3:0]};
						b[5] = "u";
						n = 4'd6;
					end
				end else begin
					b[0] = CH_TAB;
					n = 4'd1;
				end
			end
			KEY_BACKSPACE: begin
				b[0] = (ctrl != cfg.bs_is_del) ? CH_DEL : CH_BS;
				n = 4'd1;
			end
			KEY_ESCAPE: begin
				b[0] = CH_ESC;
				n = 4'd1;
			end
			[KEY_UP:KEY_END]: begin
				rel = key - KEY_UP;
				fin = cursor_final(rel[2:0]);
				app = cfg.cursor_ss3;
				do_cursor = 1'b1;
			end
			[KEY_INSERT:KEY_PAGE_DOWN]: begin
				rel = key - KEY_INSERT;
				num = tilde_named(rel[1:0]);
				do_tilde = 1'b1;
			end
			[KEY_F1:KEY_F4]: begin
				rel = key - KEY_F1;
				fin = ss3_final(rel[1:0]);
				app = 1'b1;
				do_cursor = 1'b1;
			end
			[KEY_F5:KEY_F20]: begin
				rel = key - KEY_F5;
				num = fkey_tilde(rel[3:0]);
				do_tilde = 1'b1;
			end
			[KEY_KP_0:KEY_KP_EQUALS]: begin
				rel = key - KEY_KP_0;
				if (cfg.keypad_app) begin
					b[0] = CH_ESC;
					b[1] = "O";
					b[2] = kp_app(rel[4:0]);
					n = 4'd3;
				end else if (rel[4:0] == KP_ENTER_IDX) begin
					b[0] = CH_CR;
					b[1] = CH_LF;
					n = cfg.crlf_on_enter ? 4'd2 : 4'd1;
				end else begin
					b[0] = kp_num(rel[4:0]);
					n = 4'd1;
				end
			end
			default: begin
				n = 4'd0;
			end
		endcase

		// ESC [ 1 ; mod final, or ESC O/[ final
		if (do_cursor) begin
			b[0] = CH_ESC;
			if (mod > 5'd1) begin
				b[1] = "[";
				b[2] = "1";
				b[3] = ";";
				if (mod >= 5'd10) begin
					b[4] = "1";
					b[5] = dec_ones(modw, 2'd1);
					b[6] = fin;
					n = 4'd7;
				end else begin
					b[4] = 8'h30 | {4'd0, mod[3:0]};
					b[5] = fin;
					n = 4'd6;
				end
			end else begin
				b[1] = app ? "O" : "[";
				b[2] = fin;
				n = 4'd3;
			end
		end

		// ESC [ num [; mod] ~
		if (do_tilde) begin
			t = dec_tens(num);
			b[0] = CH_ESC;
			b[1] = "[";
			n = 4'd2;
			if (t != 2'd0) begin
				b[n[2:0]] = 8'h30 | {6'd0, t};
				n = n + 4'd1;
			end
			b[n[2:0]] = dec_ones(num, t);
			n = n + 4'd1;
			if (mod > 5'd1) begin
				b[n[2:0]] = ";";
				n = n + 4'd1;
				if (mod >= 5'd10) begin
					b[n[2:0]] = "1";
					n = n + 4'd1;
					b[n[2:0]] = dec_ones(modw, 2'd1);
				end else begin
					b[n[2:0]] = 8'h30 | {4'd0, mod[3:0]};
				end
				n = n + 4'd1;
			end
			b[n[2:0]] = "~";
			n = n + 4'd1;
		end

		// alt prefix on single bytes and bodies that do not open with ESC
		do_alt = alt && cfg.alt_esc_prefix && n != 4'd0 && (n == 4'd1 || b[0] != CH_ESC);
		if (do_alt) begin
			push_seq.bytes[0] = CH_ESC;
			for (int i = 1; i < SEQ_MAX; i++) push_seq.bytes[i] = b[i-1];
			push_seq.len = (n == 4'(SEQ_MAX)) ? n : n + 4'd1;
		end else begin
			for (int i = 0; i < SEQ_MAX; i++) push_seq.bytes[i] = b[i];
			push_seq.len = n;
		end
	end

	// events that encode to nothing are dropped here
	assign push = valid_s1 && !qstat.full && (n != 4'd0);

endmodule

// ----- rtl/kee_queue.sv -----
// ----------------------------------------------------------------------------
// kee_queue
// Two-entry queue of encoded sequences between front and back.
// ----------------------------------------------------------------------------
module kee_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kee_pkg::kee_seq_t  push_seq,
	input  logic               pop,
	output kee_pkg::kee_seq_t  head,
	output kee_pkg::kee_qstat_t qstat
);
	import kee_pkg::*;

	kee_seq_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_seq;
		end
	end

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = count_q == 2'd2;
	assign qstat.valid = count_q != 2'd0;

endmodule

// ----- rtl/kee_back.sv -----
// ----------------------------------------------------------------------------
// kee_back
// Walks the queued sequence, one byte a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module kee_back (
	input  logic                clk,
	input  logic                arst_n,
	input  kee_pkg::kee_seq_t   head,
	input  kee_pkg::kee_qstat_t qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output kee_pkg::kee_out_t   out_item
);
	import kee_pkg::*;

	logic       out_valid_q;
	kee_out_t   out_q;
	logic [2:0] idx_q;
	logic [3:0] len_m1;
	logic       load, is_last;

	assign len_m1  = head.len - 4'd1;
	assign is_last = idx_q == len_m1[2:0];
	// output register refills as soon as the current byte leaves
	assign load    = qstat.valid && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= head.bytes[idx_q];
			out_q.last     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- rtl/key_event_escape_encoder_core.sv -----
// ----------------------------------------------------------------------------
// key_event_escape_encoder_core
// Encodes key events into xterm escape byte sequences.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    key_code, modifiers, char_code
//   out      output     out_valid/out_stall  out_byte, last
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// an event is registered in the encode stage and encodes to 1 to 8 bytes,
// then one byte leaves per cycle while out_stall is low
// the output byte stepper sets the sustained rate; events that encode to
// nothing are dropped before the queue and never reach the output
// a two-entry queue lets the encode stage take new events while bytes drain
// reset clears all control and the configuration registers to zero
// ----------------------------------------------------------------------------
module key_event_escape_encoder_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  kee_pkg::kee_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output kee_pkg::kee_out_t out_item,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic              cfg_data
);
	import kee_pkg::*;

	kee_cfg_t   cfg_q;
	kee_qstat_t qstat;
	kee_seq_t   push_seq;
	kee_seq_t   head;
	logic       push;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NEWLINE_MODE: cfg_q.crlf_on_enter  <= cfg_data;
				CFG_BS_DELETE:    cfg_q.bs_is_del      <= cfg_data;
				CFG_APP_CURSOR:   cfg_q.cursor_ss3     <= cfg_data;
				CFG_APP_KEYPAD:   cfg_q.keypad_app     <= cfg_data;
				CFG_ALT_ESCAPE:   cfg_q.alt_esc_prefix <= cfg_data;
				default: ;
			endcase
		end
	end

	kee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.push     (push),
		.push_seq (push_seq)
	);

	kee_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_seq (push_seq),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	kee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
